FILE: design/deq_pkg.sv
// Shared command, status and control types for the double-ended queue.
package deq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_REAR  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Decision that the pointer logic hands to the storage and result path.
  typedef struct packed {
    logic    wr_en;
    logic    pop_ok;
    status_t status;
  } ctl_t;

endpackage

FILE: design/double_ended_queue.sv
// Top level of the double-ended queue: entry memory, pointers and result register.
//
//   channel   ports                                              direction
//   command   start, busy, in_cmd, in_data_in                    in
//   result    out_valid, out_data_out, out_status, out_length,   out
//             out_is_empty
//
// A command is taken on each edge with start high and busy low; its result
// shows on the out_ ports for one cycle, in the cycle after it is taken, with out_valid high.
// Commands may follow in every cycle while busy is low: the entry memory is read
// on the accept edge, so the pointer update and the memory read set the rate.
// busy is high in reset and until the first edge after it. Results cannot be held off.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  output logic [31:0] out_data_out,
  output logic [1:0]  out_status,
  output logic [4:0]  out_length,
  output logic        out_is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         head_r, head_nxt, tail_r, tail_nxt, wr_addr, rd_addr;
  logic [CW-1:0]         count_r, count_nxt;
  ctl_t                  ctl;
  logic                  accept;
  logic                  busy_r;
  logic                  valid_r;
  logic                  pop_ok_r;
  status_t               status_r;
  logic [CW-1:0]         len_r;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH+31:0] din_ext;
  logic [DATA_WIDTH+31:0] dout_ext;
  logic [CW+4:0]         len_ext;

  assign accept = start && !busy_r;

  deq_ptr #(.DEPTH(DEPTH)) u_ptr (
    .cmd      (in_cmd),
    .head     (head_r),
    .tail     (tail_r),
    .count    (count_r),
    .head_nxt (head_nxt),
    .tail_nxt (tail_nxt),
    .count_nxt(count_nxt),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .ctl      (ctl)
  );

  assign din_ext = {DATA_WIDTH'(0), in_data_in};

  // Only one command touches the memory per edge, so a pop always sees
  // the word written by any earlier push.
  always_ff @(posedge clk) begin
    if (accept && ctl.wr_en) begin
      mem[wr_addr] <= din_ext[DATA_WIDTH-1:0];
    end
    if (accept && ctl.pop_ok) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      valid_r  <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      pop_ok_r <= 1'b0;
      status_r <= ST_OK;
      len_r    <= '0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= accept;
      if (accept) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        count_r  <= count_nxt;
        pop_ok_r <= ctl.pop_ok;
        status_r <= ctl.status;
        len_r    <= count_nxt;
      end
    end
  end

  assign dout_ext     = {32'd0, rd_data_r};
  assign len_ext      = {5'd0, len_r};
  assign busy         = busy_r;
  assign out_valid    = valid_r;
  assign out_data_out = pop_ok_r ? dout_ext[31:0] : 32'd0;
  assign out_status   = status_r;
  assign out_length   = len_ext[4:0];
  assign out_is_empty = (len_r == '0);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_empty_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (count_r == '0)))
    else $error("empty flag disagrees with entry count");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_data_out == 32'd0))
    else $error("refused command returned data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ctl.status == ST_FULL) |=> (count_r == CW'(DEPTH)))
    else $error("push refused while not full");

endmodule

FILE: design/deq_ptr.sv
// Head, tail and count update logic with memory address selection.
module deq_ptr import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic [2:0]                   cmd,
  input  logic [$clog2(DEPTH)-1:0]     head,
  input  logic [$clog2(DEPTH)-1:0]     tail,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output logic [$clog2(DEPTH)-1:0]     head_nxt,
  output logic [$clog2(DEPTH)-1:0]     tail_nxt,
  output logic [$clog2(DEPTH+1)-1:0]   count_nxt,
  output logic [$clog2(DEPTH)-1:0]     wr_addr,
  output logic [$clog2(DEPTH)-1:0]     rd_addr,
  output ctl_t                         ctl
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic          full, empty;

  assign head_inc = (head == AW'(DEPTH-1)) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? AW'(DEPTH-1) : head - AW'(1);
  assign tail_inc = (tail == AW'(DEPTH-1)) ? '0 : tail + AW'(1);
  assign tail_dec = (tail == '0) ? AW'(DEPTH-1) : tail - AW'(1);
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    head_nxt   = head;
    tail_nxt   = tail;
    count_nxt  = count;
    wr_addr    = tail;
    rd_addr    = head;
    ctl.wr_en  = 1'b0;
    ctl.pop_ok = 1'b0;
    ctl.status = ST_OK;
    case (cmd)
      CMD_PUSH_REAR: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.wr_en = 1'b1;
          wr_addr   = tail;
          tail_nxt  = tail_inc;
          count_nxt = count + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.wr_en = 1'b1;
          wr_addr   = head_dec;
          head_nxt  = head_dec;
          count_nxt = count + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.pop_ok = 1'b1;
          rd_addr    = head;
          head_nxt   = head_inc;
          count_nxt  = count - CW'(1);
        end
      end
      CMD_POP_REAR: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.pop_ok = 1'b1;
          rd_addr    = tail_dec;
          tail_nxt   = tail_dec;
          count_nxt  = count - CW'(1);
        end
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        tail_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the double-ended queue: directed table, then random commands.
module tb_top;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam int CYCLE_LIMIT = 200_000;
  // Command codes the block must ignore.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [31:0] data;
    status_t     status;
    logic [4:0]  length;
    logic        is_empty;
  } deq_beat_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] data;
    logic [4:0]  reps;
    logic        typed;
    deq_beat_t   exp;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_cmd;
  logic [31:0] in_data_in;
  logic        out_valid;
  logic [31:0] out_data_out;
  logic [1:0]  out_status;
  logic [4:0]  out_length;
  logic        out_is_empty;

  // Typed expectation that travels with the beat currently on the command port.
  logic        cur_typed;
  deq_beat_t   cur_exp;

  deq_beat_t   expected_beats[$];
  int          error_count = 0;
  int          accepted_count = 0;
  int          full_refusals = 0;
  int          empty_refusals = 0;
  int          peak_length = 0;
  int          cycle_count = 0;

  // Shadow of the queue contents; 4-bit pointers wrap on their own at depth 16.
  logic [31:0] ring [QDEPTH];
  logic [3:0]  head_ptr = '0;
  logic [3:0]  tail_ptr = '0;
  logic [4:0]  entry_count = '0;

  // Rows with typed = 1 carry the result written out by hand; the rest use the predictor.
  stim_row_t directed_rows [0:12] = '{
    '{CMD_POP_FRONT,  32'h1234_5678, 5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}},
    '{CMD_UNUSED_HI,  32'hDEAD_BEEF, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd0, 1'b1}},
    '{CMD_PUSH_REAR,  32'hFFFF_FFFF, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd1, 1'b0}},
    '{CMD_PUSH_FRONT, 32'h0000_0000, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd2, 1'b0}},
    '{CMD_POP_REAR,   32'h0000_0000, 5'd1, 1'b1, '{32'hFFFF_FFFF, ST_OK, 5'd1, 1'b0}},
    '{CMD_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd0, 1'b1}},
    '{CMD_PUSH_FRONT, 32'h8000_0001, 5'd8, 1'b0, '{32'h0, ST_OK, 5'd0, 1'b0}},
    '{CMD_PUSH_REAR,  32'h7FFF_FFF0, 5'd8, 1'b0, '{32'h0, ST_OK, 5'd0, 1'b0}},
    '{CMD_PUSH_REAR,  32'h5555_5555, 5'd1, 1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
    '{CMD_PUSH_FRONT, 32'hAAAA_AAAA, 5'd1, 1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
    '{CMD_UNUSED_LO,  32'h0000_0000, 5'd1, 1'b0, '{32'h0, ST_OK, 5'd0, 1'b0}},
    '{CMD_CLEAR,      32'h0000_0000, 5'd1, 1'b1, '{32'h0, ST_OK, 5'd0, 1'b1}},
    '{CMD_POP_REAR,   32'h0000_0000, 5'd1, 1'b1, '{32'h0, ST_EMPTY, 5'd0, 1'b1}}
  };

  double_ended_queue #(
    .DEPTH(QDEPTH),
    .DATA_WIDTH(32)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_data_in(in_data_in),
    .out_valid(out_valid),
    .out_data_out(out_data_out),
    .out_status(out_status),
    .out_length(out_length),
    .out_is_empty(out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic deq_beat_t apply_deque_cmd(logic [2:0] c, logic [31:0] w);
    deq_beat_t r;
    r = '{32'h0, ST_OK, 5'd0, 1'b0};
    case (c)
      CMD_PUSH_REAR: begin
        if (entry_count == QDEPTH) begin
          r.status = ST_FULL;
          full_refusals++;
        end else begin
          ring[tail_ptr] = w;
          tail_ptr = tail_ptr + 4'd1;
          entry_count = entry_count + 5'd1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (entry_count == QDEPTH) begin
          r.status = ST_FULL;
          full_refusals++;
        end else begin
          head_ptr = head_ptr - 4'd1;
          ring[head_ptr] = w;
          entry_count = entry_count + 5'd1;
        end
      end
      CMD_POP_FRONT: begin
        if (entry_count == 0) begin
          r.status = ST_EMPTY;
          empty_refusals++;
        end else begin
          r.data = ring[head_ptr];
          head_ptr = head_ptr + 4'd1;
          entry_count = entry_count - 5'd1;
        end
      end
      CMD_POP_REAR: begin
        if (entry_count == 0) begin
          r.status = ST_EMPTY;
          empty_refusals++;
        end else begin
          tail_ptr = tail_ptr - 4'd1;
          r.data = ring[tail_ptr];
          entry_count = entry_count - 5'd1;
        end
      end
      CMD_CLEAR: begin
        head_ptr = '0;
        tail_ptr = '0;
        entry_count = '0;
      end
      default: ;
    endcase
    if (entry_count > peak_length) peak_length = entry_count;
    r.length = entry_count;
    r.is_empty = (entry_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Results are checked before the beat accepted at the same edge is predicted,
  // since the block answers in the cycle after it takes a command.
  always @(posedge clk) begin
    deq_beat_t exp;
    deq_beat_t pred;
    if (rst_n) begin
      if (out_valid !== 1'b0) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with no command waiting");
        end else begin
          exp = expected_beats.pop_front();
          if (out_data_out !== exp.data)
            report_mismatch($sformatf("data_out %h, want %h", out_data_out, exp.data));
          if (out_status !== exp.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, exp.status));
          if (out_length !== exp.length)
            report_mismatch($sformatf("length %0d, want %0d", out_length, exp.length));
          if (out_is_empty !== exp.is_empty)
            report_mismatch($sformatf("is_empty %b, want %b", out_is_empty, exp.is_empty));
        end
      end
      if (start && !busy) begin
        pred = apply_deque_cmd(in_cmd, in_data_in);
        expected_beats.push_back(cur_typed ? cur_exp : pred);
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_beats.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Presents one command beat and returns at the edge that takes it.
  task automatic send_cmd(input logic [2:0] c, input logic [31:0] w,
                          input logic typed, input deq_beat_t exp);
    start <= 1'b1;
    in_cmd <= c;
    in_data_in <= w;
    cur_typed <= typed;
    cur_exp <= exp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Segments lean toward pushes or pops so the queue runs both full and empty.
  // Each cycle is left idle with probability idle_pct percent.
  task automatic run_random(input int count, input int idle_pct);
    int push_pct;
    int pick;
    logic [2:0] c;
    logic [31:0] w;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 24 == 0) begin
        pick = $urandom_range(0, 2);
        push_pct = (pick == 0) ? 25 : (pick == 1) ? 50 : 80;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2)
        c = CMD_CLEAR;
      else if (pick < 5)
        c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else if ($urandom_range(0, 99) < push_pct)
        c = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      else
        c = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
      case ($urandom_range(0, 9))
        0: w = '0;
        1: w = '1;
        default: w = $urandom;
      endcase
      while ($urandom_range(0, 99) < idle_pct) hold_off(1);
      send_cmd(c, w, 1'b0, '0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_CLEAR;
    in_data_in = '0;
    cur_typed = 1'b0;
    cur_exp = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < $size(directed_rows); r++) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_cmd(directed_rows[r].cmd, directed_rows[r].data + k,
                 directed_rows[r].typed, directed_rows[r].exp);
      end
    end
    drain_results();

    run_random(320, 18);
    drain_results();
    run_random(320, 58);
    drain_results();
    run_random(310, 0);
    drain_results();
    repeat (4) @(posedge clk);

    $display("%0d commands checked; %0d pushes refused as full, %0d pops refused as empty",
             accepted_count, full_refusals, empty_refusals);
    $display("peak length %0d of %0d, %0d mismatches", peak_length, QDEPTH, error_count);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
